/* design/phq_pkg.sv */
// Package for the proximity hysteresis qualifier: event opcodes, register
// indexes and reset values. No dependencies.
package phq_pkg;

   localparam int unsigned DistWidth   = 16;
   localparam int unsigned WeightWidth = 4;
   localparam int unsigned OpWidth     = 3;

   localparam logic [DistWidth-1:0]   LOW_THRESHOLD_RESET_MM  = 16'd70;
   localparam logic [DistWidth-1:0]   HIGH_THRESHOLD_RESET_MM = 16'd75;
   localparam logic [WeightWidth-1:0] WEIGHT_CEILING_RESET    = 4'd2;
   localparam logic [WeightWidth-1:0] WEIGHT_MAX              = 4'd15;

   typedef enum logic [OpWidth-1:0] {
      OP_DISTANCE  = 3'd0,
      OP_TIMESTAMP = 3'd1,
      OP_FLUSH     = 3'd2,
      OP_SYNC      = 3'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_LOW_THRESHOLD  = 2'd0,
      REG_HIGH_THRESHOLD = 2'd1,
      REG_WEIGHT_CEILING = 2'd2,
      REG_SENSOR_ENABLED = 2'd3
   } reg_index_type;

   typedef enum logic {
      KIND_PROXIMITY = 1'b0,
      KIND_FLUSH     = 1'b1
   } report_kind_type;

endpackage

/* design/proximity_hysteresis_qualifier.sv */
// An accepted beat is captured in the input register and decoded from there;
// a report passes through the output register onto rsp_. Throughput: one
// beat per cycle, bounded only by the single output register under rsp_stall.
// Reset (synchronous, active high) restores default thresholds and ceiling,
// disables the sensor, resets the qualifier state (the mode watches for far) and clears both valid flags.
// Top level of the proximity hysteresis qualifier; uses phq_pkg.
module proximity_hysteresis_qualifier (
   input  logic        clock,
   input  logic        reset,
   // event channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_event_value,
   // report channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_report_kind,
   output logic        rsp_proximity_far,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // config registers
   logic [15:0] low_thr_ff,  low_thr_in;
   logic [15:0] high_thr_ff, high_thr_in;
   logic [3:0]  ceiling_ff,  ceiling_in;
   logic        enabled_ff,  enabled_in;

   // qualifier state
   logic        ts_seen_ff,   ts_seen_in;
   logic [15:0] latest_ff,    latest_in;
   logic        flush_pend_ff, flush_pend_in;
   logic        class_far_ff, class_far_in;
   logic [3:0]  weight_ff,    weight_in;
   logic        cross_high_ff, cross_high_in;
   logic        rpt_pend_ff,  rpt_pend_in;
   logic        rpt_far_ff,   rpt_far_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [2:0]  in_op_ff,    in_op_in;
   logic [15:0] in_val_ff,   in_val_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff,  out_kind_in;
   logic        out_far_ff,   out_far_in;

   logic        req_take;
   logic        advance;
   logic        csr_write;
   logic [1:0]  csr_index;

   // qualify datapath
   logic        is_sync;
   logic        do_qualify;
   logic [15:0] q_dist;
   logic        q_near, q_far, q_classed;
   logic        q_class;
   logic [3:0]  q_base;
   logic [3:0]  q_weight;
   logic        q_reached;
   logic        q_mode_flip;
   logic        rp_after;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      prdata = '0;
      unique case (phq_pkg::reg_index_type'(csr_index))
         phq_pkg::REG_LOW_THRESHOLD:  prdata = {16'd0, low_thr_ff};
         phq_pkg::REG_HIGH_THRESHOLD: prdata = {16'd0, high_thr_ff};
         phq_pkg::REG_WEIGHT_CEILING: prdata = {28'd0, ceiling_ff};
         phq_pkg::REG_SENSOR_ENABLED: prdata = {31'd0, enabled_ff};
         default:                     prdata = '0;
      endcase
   end

   // handshake: the input register moves on whenever the output register
   // is empty or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign in_op_in    = req_take ? req_opcode      : in_op_ff;
   assign in_val_in   = req_take ? req_event_value : in_val_ff;

   // hysteresis classification and weight counter
   assign is_sync    = (in_op_ff == 3'(phq_pkg::OP_SYNC));
   assign q_dist     = is_sync ? latest_ff : in_val_ff;
   assign do_qualify = is_sync
                     ? (!flush_pend_ff && ts_seen_ff)
                     : (enabled_ff && !ts_seen_ff && in_op_ff == 3'(phq_pkg::OP_DISTANCE));
   assign q_near      = (q_dist <= low_thr_ff);
   assign q_far       = !q_near && (q_dist >= high_thr_ff);
   assign q_classed   = q_near || q_far;
   assign q_class     = q_classed ? q_far : class_far_ff;
   assign q_base      = (q_classed && (q_far != class_far_ff)) ? 4'd0 : weight_ff;
   assign q_weight    = (q_classed && q_base != phq_pkg::WEIGHT_MAX) ? q_base + 4'd1 : q_base;
   assign q_reached   = (q_weight >= ceiling_ff);
   // mode watches for far while near; a flip arms a report
   assign q_mode_flip = q_reached && (cross_high_ff != !q_class);
   assign rp_after    = rpt_pend_ff || (do_qualify && q_mode_flip);

   always_comb begin
      low_thr_in    = low_thr_ff;
      high_thr_in   = high_thr_ff;
      ceiling_in    = ceiling_ff;
      enabled_in    = enabled_ff;
      ts_seen_in    = ts_seen_ff;
      latest_in     = latest_ff;
      flush_pend_in = flush_pend_ff;
      class_far_in  = class_far_ff;
      weight_in     = weight_ff;
      cross_high_in = cross_high_ff;
      rpt_pend_in   = rpt_pend_ff;
      rpt_far_in    = rpt_far_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_far_in    = out_far_ff;

      if (in_valid_ff && advance) begin
         if (do_qualify) begin
            class_far_in = q_class;
            weight_in    = q_weight;
            if (q_reached) begin
               rpt_far_in = q_class;
            end
            if (q_mode_flip) begin
               cross_high_in = !q_class;
               rpt_pend_in   = 1'b1;
            end
         end
         if (is_sync) begin
            if (flush_pend_ff) begin
               flush_pend_in = 1'b0;
               out_valid_in  = 1'b1;
               out_kind_in   = phq_pkg::KIND_FLUSH;
               out_far_in    = 1'b0;
            end else begin
               ts_seen_in = 1'b0;
               if (rp_after) begin
                  rpt_pend_in  = 1'b0;
                  out_valid_in = 1'b1;
                  out_kind_in  = phq_pkg::KIND_PROXIMITY;
                  out_far_in   = q_reached && do_qualify ? q_class : rpt_far_ff;
               end
            end
         end else if (enabled_ff) begin
            if (in_op_ff == 3'(phq_pkg::OP_DISTANCE)) begin
               latest_in = in_val_ff;
            end else if (in_op_ff == 3'(phq_pkg::OP_TIMESTAMP)) begin
               ts_seen_in = 1'b1;
            end else if (in_op_ff == 3'(phq_pkg::OP_FLUSH)) begin
               flush_pend_in = 1'b1;
            end
         end
      end

      // register writes must arrive only while idle; the block does not enforce this
      if (csr_write) begin
         unique case (phq_pkg::reg_index_type'(csr_index))
            phq_pkg::REG_LOW_THRESHOLD:  low_thr_in  = pwdata[15:0];
            phq_pkg::REG_HIGH_THRESHOLD: high_thr_in = pwdata[15:0];
            phq_pkg::REG_WEIGHT_CEILING: ceiling_in  = pwdata[3:0];
            phq_pkg::REG_SENSOR_ENABLED: begin
               enabled_in = pwdata[0];
               if (pwdata[0]) begin
                  class_far_in  = 1'b0;
                  cross_high_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff    <= phq_pkg::LOW_THRESHOLD_RESET_MM;
         high_thr_ff   <= phq_pkg::HIGH_THRESHOLD_RESET_MM;
         ceiling_ff    <= phq_pkg::WEIGHT_CEILING_RESET;
         enabled_ff    <= 1'b0;
         ts_seen_ff    <= 1'b0;
         latest_ff     <= '0;
         flush_pend_ff <= 1'b0;
         class_far_ff  <= 1'b0;
         weight_ff     <= '0;
         cross_high_ff <= 1'b1;
         rpt_pend_ff   <= 1'b0;
         rpt_far_ff    <= 1'b0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         low_thr_ff    <= low_thr_in;
         high_thr_ff   <= high_thr_in;
         ceiling_ff    <= ceiling_in;
         enabled_ff    <= enabled_in;
         ts_seen_ff    <= ts_seen_in;
         latest_ff     <= latest_in;
         flush_pend_ff <= flush_pend_in;
         class_far_ff  <= class_far_in;
         weight_ff     <= weight_in;
         cross_high_ff <= cross_high_in;
         rpt_pend_ff   <= rpt_pend_in;
         rpt_far_ff    <= rpt_far_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_val_ff   <= in_val_in;
      out_kind_ff <= out_kind_in;
      out_far_ff  <= out_far_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_report_kind   = out_kind_ff;
   assign rsp_proximity_far = out_far_ff;

endmodule

/* design/phq_checker.sv */
// Port-level checks for the proximity hysteresis qualifier, bound to the top
// level. Uses phq_pkg for the sync opcode.
module phq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_report_kind,
   input logic        rsp_proximity_far
);

   // a held report beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_report_kind)
                                 && $stable(rsp_proximity_far))
      else $error("report beat changed while stalled");

   a_flush_near: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_kind |-> !rsp_proximity_far)
      else $error("flush-complete report carries far");

   // a fresh report follows an accepted sync beat through the input and output registers
   a_from_sync: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall
                                 && req_opcode == 3'(phq_pkg::OP_SYNC), 2))
      else $error("report without a preceding sync");

   // input side only backs up behind a blocked report
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("event channel stalled with report side free");

endmodule

bind proximity_hysteresis_qualifier phq_checker u_phq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_report_kind   (rsp_report_kind),
   .rsp_proximity_far (rsp_proximity_far)
);
